// ===== rtl/core/btgr_pkg.sv =====
// btgr_pkg: shared types, constants and the 5x7 font rom for the glyph renderer
// depends on nothing; imported by the interfaces and by every module but btgr_fifo
package btgr_pkg;

  localparam int GLYPH_ROWS      = 7;
  localparam int GLYPH_COLS      = 5;
  localparam int COLOR_W         = 16;
  localparam int SCALE_W         = 4;
  localparam int CODE_W          = 8;
  localparam int ROW_IDX_W       = 3;
  localparam int COL_IDX_W       = 3;

  localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(GLYPH_ROWS - 1);
  localparam logic [COL_IDX_W-1:0] LAST_COL = COL_IDX_W'(GLYPH_COLS - 1);

  // row 0 is the top row; bit 4 of a row is the leftmost column
  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_t;

  function automatic glyph_t glyph_lookup(input logic [CODE_W-1:0] code);
    glyph_t g;
    case (code)
      "0": g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      "1": g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "2": g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      "3": g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "4": g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      "5": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      "6": g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      "7": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      "8": g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      "9": g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
      "A": g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "B": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      "C": g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      "D": g = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
      "E": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      "G": g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      "I": g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "L": g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "M": g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      "N": g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      "O": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "P": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      "Q": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      "R": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      "S": g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "T": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "U": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "V": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      "Y": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      ":": g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      ".": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06};
      "%": g = {5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13};
      "-": g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      default: g = '0;  // space and every code outside the font
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/core/btgr_ifs.sv =====
// btgr_ifs: valid/ready channel interfaces for character requests and block results
// depends on btgr_pkg for field widths
interface btgr_in_if #(parameter int COORD_BITS = 12);
  import btgr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CODE_W-1:0]     char_code;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COLOR_W-1:0]    fg_color;
  logic [COLOR_W-1:0]    bg_color;
  logic [SCALE_W-1:0]    scale;
  logic                  first_char;

  modport source (output valid, char_code, start_x, start_y, fg_color, bg_color, scale,
                  first_char, input ready);
  modport sink   (input valid, char_code, start_x, start_y, fg_color, bg_color, scale,
                  first_char, output ready);
endinterface

interface btgr_out_if #(parameter int COORD_BITS = 12);
  import btgr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] block_x;
  logic [COORD_BITS-1:0] block_y;
  logic [COLOR_W-1:0]    block_color;
  logic [SCALE_W-1:0]    block_size;
  logic                  last_block;

  modport source (output valid, block_x, block_y, block_color, block_size, last_block,
                  input ready);
  modport sink   (input valid, block_x, block_y, block_color, block_size, last_block,
                  output ready);
endinterface

// ===== rtl/core/btgr_front.sv =====
// btgr_front: accepts character requests, clamps scale, keeps the cursor, looks up glyph
// depends on btgr_pkg and btgr_in_if; pushes one descriptor per drawable character
module btgr_front #(
  parameter int MAX_SCALE  = 8,
  parameter int COORD_BITS = 12,
  parameter int DESC_W     = 2 * COORD_BITS + 2 * 16 + 4 + 35
) (
  input  logic              clk,
  input  logic              rst_n,
  btgr_in_if.sink           in_chan,
  input  logic              q_full,
  output logic              q_push,
  output logic [DESC_W-1:0] q_wdata
);
  import btgr_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_W-1:0]    fg;
    logic [COLOR_W-1:0]    bg;
    logic [SCALE_W-1:0]    size;
    glyph_t                glyph;
  } desc_t;

  logic [COORD_BITS-1:0] cursor_r, cursor_nxt;
  logic [SCALE_W-1:0]    scale_c;
  logic [COORD_BITS-1:0] base_x;
  logic [SCALE_W+2:0]    advance;
  logic [COORD_BITS:0]   adv_sum;
  logic                  accept;
  desc_t                 desc;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    if ({1'b0, in_chan.scale} > (SCALE_W + 1)'(MAX_SCALE)) begin
      scale_c = SCALE_W'(MAX_SCALE);
    end else begin
      scale_c = in_chan.scale;
    end
  end

  assign base_x  = in_chan.first_char ? in_chan.start_x : cursor_r;
  // six times scale as four plus two
  assign advance = {1'b0, scale_c, 2'b00} + {2'b00, scale_c, 1'b0};
  assign adv_sum = {1'b0, base_x} + (COORD_BITS + 1)'(advance);
  assign cursor_nxt = adv_sum[COORD_BITS] ? '1 : adv_sum[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else if (accept) begin
      cursor_r <= cursor_nxt;
    end
  end

  always_comb begin
    desc.x     = base_x;
    desc.y     = in_chan.start_y;
    desc.fg    = in_chan.fg_color;
    desc.bg    = in_chan.bg_color;
    desc.size  = scale_c;
    desc.glyph = glyph_lookup(in_chan.char_code);
  end

  // zero scale pushes no descriptor and only updates the cursor, which it does not advance
  assign q_push  = accept && (scale_c != '0);
  assign q_wdata = DESC_W'(desc);

endmodule

// ===== rtl/core/btgr_fifo.sv =====
// btgr_fifo: two-entry descriptor queue between front and back ends
// depends on nothing but its data width parameter
module btgr_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output logic [DATA_W-1:0] rdata
);
  localparam int DEPTH = 2;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r;

  assign full      = (count_r == 2'(DEPTH));
  assign not_empty = (count_r != 2'd0);
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/btgr_back.sv =====
// btgr_back: walks the 35 glyph cells of the head descriptor, one block result per cycle
// unless stalled; needs btgr_pkg, btgr_out_if; output register parts it from consumer
module btgr_back #(
  parameter int COORD_BITS = 12,
  parameter int DESC_W     = 2 * COORD_BITS + 2 * 16 + 4 + 35
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  logic [DESC_W-1:0] q_rdata,
  output logic              q_pop,
  btgr_out_if.source        out_chan
);
  import btgr_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_W-1:0]    fg;
    logic [COLOR_W-1:0]    bg;
    logic [SCALE_W-1:0]    size;
    glyph_t                glyph;
  } desc_t;

  desc_t                       head;
  logic [ROW_IDX_W-1:0]        row_r;
  logic [COL_IDX_W-1:0]        col_r;
  logic                        load;
  logic                        last_cell;
  logic [COL_IDX_W+SCALE_W-1:0] x_off;
  logic [ROW_IDX_W+SCALE_W-1:0] y_off;
  logic [COORD_BITS:0]         x_sum, y_sum;
  logic [COL_IDX_W-1:0]        bit_idx;
  logic                        lit;

  logic                  out_valid_r;
  logic [COORD_BITS-1:0] block_x_r, block_y_r;
  logic [COLOR_W-1:0]    block_color_r;
  logic [SCALE_W-1:0]    block_size_r;
  logic                  last_block_r;

  assign head      = desc_t'(q_rdata);
  assign load      = q_not_empty && (!out_valid_r || out_chan.ready);
  assign last_cell = (row_r == LAST_ROW) && (col_r == LAST_COL);
  assign q_pop     = load && last_cell;

  assign x_off   = {{SCALE_W{1'b0}}, col_r} * {{COL_IDX_W{1'b0}}, head.size};
  assign y_off   = {{SCALE_W{1'b0}}, row_r} * {{ROW_IDX_W{1'b0}}, head.size};
  assign x_sum   = {1'b0, head.x} + (COORD_BITS + 1)'(x_off);
  assign y_sum   = {1'b0, head.y} + (COORD_BITS + 1)'(y_off);
  assign bit_idx = LAST_COL - col_r;
  assign lit     = head.glyph[row_r][bit_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        if (col_r == LAST_COL) begin
          col_r <= '0;
          row_r <= last_cell ? '0 : row_r + ROW_IDX_W'(1);
        end else begin
          col_r <= col_r + COL_IDX_W'(1);
        end
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      block_x_r     <= x_sum[COORD_BITS] ? '1 : x_sum[COORD_BITS-1:0];
      block_y_r     <= y_sum[COORD_BITS] ? '1 : y_sum[COORD_BITS-1:0];
      block_color_r <= lit ? head.fg : head.bg;
      block_size_r  <= head.size;
      last_block_r  <= last_cell;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.block_x     = block_x_r;
  assign out_chan.block_y     = block_y_r;
  assign out_chan.block_color = block_color_r;
  assign out_chan.block_size  = block_size_r;
  assign out_chan.last_block  = last_block_r;

endmodule

// ===== rtl/core/bitmap_text_glyph_renderer.sv =====
// bitmap_text_glyph_renderer: 5x7 font character generator, top level
// depends on btgr_pkg, btgr_ifs, btgr_front, btgr_fifo, btgr_back
//
//   channel   | dir | handshake         | moves
//   ----------+-----+-------------------+----------------------------------------
//   in_chan   | in  | valid/ready       | one character request with position,
//             |     |                   | colors, scale and first-of-string flag
//   out_chan  | out | valid/ready       | one square block result, 35 per char
//
// the back end gives 35 blocks per character with nonzero scale, one block a cycle
// while not stalled; that single block generator sets the sustained rate.
// zero scale pushes nothing to the queue. the queue is written at the edge that
// takes the request; the output register then loads the first block from the queue.
// reset (rst_n low, synchronous) clears the cursor, the queue and the output valid.
// the front takes requests while the two-entry queue has room, so it runs ahead
// of a stalled output; the back holds its block in the output register on stall.
module bitmap_text_glyph_renderer #(
  parameter int MAX_SCALE  = 8,
  parameter int COORD_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  btgr_in_if.sink    in_chan,
  btgr_out_if.source out_chan
);
  import btgr_pkg::*;

  // descriptor: x, y, fg, bg, size, glyph
  localparam int DESC_W = 2 * COORD_BITS + 2 * COLOR_W + SCALE_W
                          + GLYPH_ROWS * GLYPH_COLS;

  logic              q_push, q_pop, q_full, q_not_empty;
  logic [DESC_W-1:0] q_wdata, q_rdata;

  // front end: clamp scale, place cursor, fetch glyph rows
  btgr_front #(
    .MAX_SCALE  (MAX_SCALE),
    .COORD_BITS (COORD_BITS),
    .DESC_W     (DESC_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // decoupling queue so request intake and block output stall independently
  btgr_fifo #(
    .DATA_W (DESC_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  // back end: row/column walk, coordinate saturation, color select
  btgr_back #(
    .COORD_BITS (COORD_BITS),
    .DESC_W     (DESC_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_chan    (out_chan)
  );

endmodule
